FILE: hw/rtl/pcs_pkg.sv
// Shared constants for the PUCT child select block.
package pcs_pkg;
	localparam int SCORE_W = 32;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
	localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
	localparam logic [15:0] GAIN_RESET = 16'd256;
	localparam logic CFG_EXPLORE = 1'b0;
	localparam logic CFG_VLOSS = 1'b1;
endpackage

FILE: hw/rtl/pcs_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module pcs_sqrt #(
	parameter int IN_W = 54,
	parameter int OUT_W = 27
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IN_W-1:0]  radicand,
	output logic             done,
	output logic [OUT_W-1:0] root
);
	localparam int CNT_W = $clog2(OUT_W + 1);
	logic [IN_W-1:0]  rad_q;
	logic [OUT_W+1:0] rem_q;
	logic [OUT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [OUT_W+1:0] trial;
	logic [OUT_W+1:0] shifted;

	assign shifted = {rem_q[OUT_W-1:0], rad_q[IN_W-1 -: 2]};
	assign trial = shifted - {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(OUT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[IN_W-3:0], 2'b00};
			if (!trial[OUT_W+1]) begin
				rem_q <= trial;
				root_q <= {root_q[OUT_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				root_q <= {root_q[OUT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

FILE: hw/rtl/pcs_div.sv
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module pcs_div #(
	parameter int NUM_W = 75,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] d_q;
	logic [DEN_W:0]   r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   sh;
	logic [DEN_W+1:0] diff;

	assign sh = {r_q[DEN_W-1:0], q_q[NUM_W-1]};
	assign diff = {1'b0, sh} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= numer;
			d_q <= denom;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				r_q <= diff[DEN_W:0];
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

FILE: hw/rtl/puct_child_select_top.sv
// Top level: PUCT score per child with running best and per-node result.
// Each child runs a serial square root, then two serial divides (one with zero child
// visits), then the running-best update; one child at a time, and a node result
// holds the block until out_ready.
// Reset clears gains to 1.0, best score to the minimum and best action to 0.
module puct_child_select_top #(
	parameter int ACTION_BITS = 11,
	parameter int VISIT_BITS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [ACTION_BITS-1:0] action_id,
	input  logic [15:0]            prior_prob,
	input  logic [VISIT_BITS-1:0]  child_visits,
	input  logic signed [15:0]     mean_value,
	input  logic signed [9:0]      pending_loss,
	input  logic [VISIT_BITS-1:0]  parent_visits,
	input  logic                   last_child,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ACTION_BITS-1:0] pick_action,
	output logic signed [31:0]     best_score,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [15:0]            cfg_data
);
	localparam int RAD_W = 2 * ((VISIT_BITS + 1 + 16 + 1) / 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int NUM_W = 32 + ROOT_W;
	localparam int DEN_W = VISIT_BITS + 1;
	localparam int W = NUM_W + 2;

	typedef enum logic [2:0] {IDLE, ROOT, DIV_U, DIV_T, ACC, HOLD} state_t;
	state_t state_q;
	logic [15:0] eg_q, vg_q;
	logic [ACTION_BITS-1:0] act_q, bact_q;
	logic [15:0] prior_q;
	logic [VISIT_BITS-1:0] vis_q;
	logic signed [15:0] mv_q;
	logic signed [9:0] pl_q;
	logic last_q;
	logic signed [31:0] bsc_q;
	logic [NUM_W-1:0] u_q;
	logic [31:0] mul_q;

	logic sq_start, sq_done, dv_start, dv_done;
	logic [ROOT_W-1:0] root;
	logic [NUM_W-1:0] numer, quot;
	logic [DEN_W-1:0] denom;
	logic [9:0] mag;

	assign in_ready = (state_q == IDLE);
	assign cfg_ready = (state_q == IDLE);
	assign mag = pl_q[9] ? 10'(-pl_q) : pl_q;

	pcs_sqrt #(.IN_W(RAD_W), .OUT_W(ROOT_W)) u_sqrt (
		.clk, .arst_n, .start(sq_start),
		.radicand(RAD_W'({({1'b0, parent_visits} + 1'b1), 16'h0000})),
		.done(sq_done), .root
	);
	pcs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk, .arst_n, .start(dv_start), .numer, .denom,
		.done(dv_done), .quot
	);

	assign sq_start = in_valid && in_ready;
	always_comb begin
		dv_start = 1'b0;
		numer = NUM_W'(mul_q) * NUM_W'(root);
		denom = DEN_W'(vis_q) + 1'b1;
		if (state_q == ROOT && sq_done) dv_start = 1'b1;
		if (state_q == DIV_U && dv_done && vis_q != '0) begin
			dv_start = 1'b1;
		end
		if (state_q == DIV_U) begin
			numer = NUM_W'({vg_q * 26'(mag), 8'h00});
			denom = DEN_W'(vis_q);
		end
	end

	logic signed [W-1:0] sc_raw, u_s, t_s;
	logic signed [31:0] sc_sat;
	always_comb begin
		u_s = W'(u_q >> 16);
		t_s = pl_q[9] ? -W'(quot) : W'(quot);
		sc_raw = (vis_q == '0) ? u_s : u_s + W'(mv_q) * 2 - t_s;
		if (sc_raw > W'(pcs_pkg::SCORE_MAX)) sc_sat = pcs_pkg::SCORE_MAX;
		else if (sc_raw < W'(pcs_pkg::SCORE_MIN)) sc_sat = pcs_pkg::SCORE_MIN;
		else sc_sat = 32'(sc_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			eg_q <= pcs_pkg::GAIN_RESET;
			vg_q <= pcs_pkg::GAIN_RESET;
			bsc_q <= pcs_pkg::SCORE_MIN;
			bact_q <= '0;
			out_valid <= 1'b0;
			best_score <= '0;
			pick_action <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == pcs_pkg::CFG_EXPLORE) eg_q <= cfg_data;
						else vg_q <= cfg_data;
					end
					if (in_valid) state_q <= ROOT;
				end
				ROOT: if (sq_done) state_q <= DIV_U;
				DIV_U: if (dv_done) state_q <= (vis_q == '0) ? ACC : DIV_T;
				DIV_T: if (dv_done) state_q <= ACC;
				ACC: begin
					if (last_q) begin
						out_valid <= 1'b1;
						bsc_q <= pcs_pkg::SCORE_MIN;
						bact_q <= '0;
						state_q <= HOLD;
						if (sc_sat > bsc_q) begin
							best_score <= sc_sat;
							pick_action <= act_q;
						end else begin
							best_score <= bsc_q;
							pick_action <= bact_q;
						end
					end else begin
						if (sc_sat > bsc_q) begin
							bsc_q <= sc_sat;
							bact_q <= act_q;
						end
						state_q <= IDLE;
					end
				end
				HOLD: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sq_start) begin
			act_q <= action_id;
			prior_q <= prior_prob;
			vis_q <= child_visits;
			mv_q <= mean_value;
			pl_q <= pending_loss;
			last_q <= last_child;
		end
		if (state_q == ROOT) mul_q <= eg_q * prior_q;
		if (state_q == DIV_U && dv_done) u_q <= quot;
	end
endmodule

FILE: tb/puct_child_select_top_tb.sv
// Testbench for puct_child_select_top: node streams with a running-best score model.
module puct_child_select_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACT_W = 11;
	localparam int VIS_W = 20;
	localparam int STALL_LIMIT = 6000;

	typedef struct {
		logic [ACT_W-1:0]   action;
		logic [15:0]        prior;
		logic [VIS_W-1:0]   visits;
		logic signed [15:0] q;
		logic signed [9:0]  loss;
		logic [VIS_W-1:0]   parent;
		logic               last;
	} child_t;

	typedef struct {
		logic [ACT_W-1:0]   action;
		logic signed [31:0] score;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ACT_W-1:0] action_id = '0;
	logic [15:0] prior_prob = '0;
	logic [VIS_W-1:0] child_visits = '0;
	logic signed [15:0] mean_value = '0;
	logic signed [9:0] pending_loss = '0;
	logic [VIS_W-1:0] parent_visits = '0;
	logic last_child = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ACT_W-1:0] pick_action;
	logic signed [31:0] best_score;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = pcs_pkg::CFG_EXPLORE;
	logic [15:0] cfg_data = '0;

	child_t children_q[$];
	pick_t picks_q[$];
	logic [15:0] model_explore = pcs_pkg::GAIN_RESET;
	logic [15:0] model_vloss = pcs_pkg::GAIN_RESET;
	longint run_best = pcs_pkg::SCORE_MIN;
	logic [ACT_W-1:0] run_action = '0;
	int errors = 0;
	int n_children = 0;
	int n_picks = 0;
	int n_sat = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	puct_child_select_top #(.ACTION_BITS(ACT_W), .VISIT_BITS(VIS_W)) DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint isqrt(longint unsigned v);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic longint puct_score(child_t c);
		longint unsigned root, num, mag;
		longint u, t, s;
		root = isqrt((longint'(c.parent) + 1) << 16);
		num = longint'(model_explore) * longint'(c.prior) * root;
		u = longint'((num / (longint'(c.visits) + 1)) >> 16);
		s = u;
		if (c.visits != 0) begin
			mag = (c.loss < 0) ? -longint'(c.loss) : longint'(c.loss);
			t = longint'(((longint'(model_vloss) * mag) << 8) / longint'(c.visits));
			if (c.loss < 0)
				t = -t;
			s = u + 2 * longint'(c.q) - t;
		end
		if (s > longint'(pcs_pkg::SCORE_MAX))
			s = pcs_pkg::SCORE_MAX;
		if (s < longint'(pcs_pkg::SCORE_MIN))
			s = pcs_pkg::SCORE_MIN;
		return s;
	endfunction

	function automatic void track_child(child_t c);
		longint s;
		pick_t p;
		s = puct_score(c);
		if (s > run_best) begin
			run_best = s;
			run_action = c.action;
		end
		if (c.last) begin
			p.action = run_action;
			p.score = run_best[31:0];
			if (run_best == longint'(pcs_pkg::SCORE_MIN))
				n_sat++;
			picks_q.insert(picks_q.size(), p);
			run_best = pcs_pkg::SCORE_MIN;
			run_action = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		child_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				c.action = action_id;
				c.prior = prior_prob;
				c.visits = child_visits;
				c.q = mean_value;
				c.loss = pending_loss;
				c.parent = parent_visits;
				c.last = last_child;
				track_child(c);
				n_children++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (children_q.size() != 0) begin
					c = children_q.pop_front();
					action_id <= c.action;
					prior_prob <= c.prior;
					child_visits <= c.visits;
					mean_value <= c.q;
					pending_loss <= c.loss;
					parent_visits <= c.parent;
					last_child <= c.last;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 6);
						gap_left <= calm ? 0 : $urandom_range(0, 400);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left <= $urandom_range(1, 40);
		end
	end

	always @(posedge clk) begin
		pick_t e;
		if (arst_n && out_valid && out_ready) begin
			n_picks++;
			if (picks_q.size() == 0) begin
				$display("%0t: unexpected result action=%0d score=%0d",
					$realtime, pick_action, best_score);
				errors++;
			end else begin
				e = picks_q.pop_front();
				if (pick_action !== e.action) begin
					$display("%0t: pick_action expected %0d actual %0d",
						$realtime, e.action, pick_action);
					errors++;
				end
				if (best_score !== e.score) begin
					$display("%0t: best_score expected %0d actual %0d",
						$realtime, e.score, best_score);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired, no transfer for %0d cycles", $realtime, idle_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_gain(logic idx, logic [15:0] value);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == pcs_pkg::CFG_EXPLORE)
			model_explore = value;
		else
			model_vloss = value;
	endtask

	task automatic drain();
		while (children_q.size() != 0 || in_valid || picks_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic child_t make_child(logic last);
		child_t c;
		c.action = ACT_W'($urandom_range(0, 2047));
		c.prior = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 5))
			0: c.visits = '0;
			1: c.visits = VIS_W'($urandom_range(0, 1048575));
			default: c.visits = VIS_W'($urandom_range(0, 300));
		endcase
		c.q = 16'($urandom_range(0, 65535));
		c.loss = 10'($urandom_range(0, 1023));
		if ($urandom_range(0, 2) != 0)
			c.loss = 10'($signed(c.loss) / 64);
		c.parent = ($urandom_range(0, 3) == 0) ? VIS_W'($urandom_range(0, 1048575))
			: VIS_W'($urandom_range(0, 5000));
		c.last = last;
		return c;
	endfunction

	function automatic child_t fixed_child(int act, int pr, int vis, int qv, int lv,
			int par, logic last);
		child_t c;
		c.action = ACT_W'(act);
		c.prior = 16'(pr);
		c.visits = VIS_W'(vis);
		c.q = 16'(qv);
		c.loss = 10'(lv);
		c.parent = VIS_W'(par);
		c.last = last;
		return c;
	endfunction

	task automatic queue_nodes(int count);
		int size, k;
		k = 0;
		while (k < count) begin
			size = $urandom_range(1, 8);
			for (int j = 0; j < size; j++)
				children_q.insert(children_q.size(), make_child(j == size - 1));
			k += size;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults after reset
		children_q.insert(children_q.size(), fixed_child(0, 0, 0, 0, 0, 0, 1'b1));
		children_q.insert(children_q.size(),
			fixed_child(2047, 65535, 0, 32767, 511, 1048575, 1'b0));
		children_q.insert(children_q.size(),
			fixed_child(5, 65535, 1048575, -32768, -512, 1048575, 1'b0));
		children_q.insert(children_q.size(), fixed_child(6, 100, 1, 32767, -512, 0, 1'b1));
		children_q.insert(children_q.size(), fixed_child(10, 4000, 3, 100, 2, 50, 1'b0));
		children_q.insert(children_q.size(), fixed_child(11, 4000, 3, 100, 2, 50, 1'b1));
		drain();

		write_gain(pcs_pkg::CFG_EXPLORE, 16'hFFFF);
		write_gain(pcs_pkg::CFG_VLOSS, 16'hFFFF);
		children_q.insert(children_q.size(), fixed_child(1, 0, 1, -32768, 511, 0, 1'b0));
		children_q.insert(children_q.size(),
			fixed_child(2, 0, 1, -32768, 511, 1048575, 1'b1));
		children_q.insert(children_q.size(), fixed_child(3, 65535, 0, 0, 0, 1048575, 1'b0));
		children_q.insert(children_q.size(),
			fixed_child(4, 65535, 1, 32767, -512, 1048575, 1'b1));
		children_q.insert(children_q.size(), fixed_child(7, 1, 1048575, 32767, -1, 1, 1'b1));
		queue_nodes(60);
		drain();

		write_gain(pcs_pkg::CFG_EXPLORE, 16'h0000);
		write_gain(pcs_pkg::CFG_VLOSS, 16'h0000);
		children_q.insert(children_q.size(), fixed_child(8, 65535, 0, -5, 9, 1000, 1'b0));
		children_q.insert(children_q.size(), fixed_child(9, 65535, 0, 5, 9, 1000, 1'b1));
		queue_nodes(60);
		drain();

		calm = 1'b1;
		queue_nodes(40);
		drain();
		calm = 1'b0;

		for (int ph = 0; ph < 5; ph++) begin
			write_gain(pcs_pkg::CFG_EXPLORE, 16'($urandom_range(0, 65535)));
			write_gain(pcs_pkg::CFG_VLOSS, (ph == 2) ? 16'd256 : 16'($urandom_range(0, 65535)));
			queue_nodes(80);
			drain();
		end

		$display("Accepted %0d children over 8 gain settings; %0d node results checked",
			n_children, n_picks);
		$display("%0d of those nodes had no child above the floor score", n_sat);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
